// ===== rtl/timed_event_priority_queue_core_assert.svh =====
// Assertion macros used by the queue datapath.
`ifndef TIMED_EVENT_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define TIMED_EVENT_PRIORITY_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define TEPQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TEPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/tepq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tepq_pkg;

    localparam int TEPQ_DEPTH      = 64;
    localparam int TEPQ_TIME_W     = 32;
    localparam int TEPQ_POS_W      = 8;
    localparam int TEPQ_WIN_W      = 8;
    localparam int TEPQ_OCC_W      = 7;
    localparam int TEPQ_IN_DATA_W  = 80;
    localparam int TEPQ_OUT_DATA_W = 64;

    localparam logic [TEPQ_WIN_W-1:0] TEPQ_WINDOW_RESET = 8'd6;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_POP    = 2'd1,
        CMD_QUERY  = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EVAL = 1'b1
    } t_state;

    typedef struct packed {
        logic [TEPQ_TIME_W-1:0] ev_time;
        logic [TEPQ_POS_W-1:0]  ev_col;
        logic [TEPQ_POS_W-1:0]  ev_row;
    } t_entry;

    typedef struct packed {
        logic accept;
        logic load;
    } t_ctrl_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== rtl/tepq_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tepq_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  tepq_pkg::t_dp_status  i_dp_status,
    output tepq_pkg::t_ctrl_cmd   o_ctrl_cmd
);
    import tepq_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        o_in_ready        = 1'b0;
        o_ctrl_cmd.accept = 1'b0;
        o_ctrl_cmd.load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready        = 1'b1;
                o_ctrl_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                o_ctrl_cmd.load = i_dp_status.out_free;
                if (i_dp_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/tepq_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "timed_event_priority_queue_core_assert.svh"

module tepq_datapath #(
    parameter int QUEUE_DEPTH = tepq_pkg::TEPQ_DEPTH
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  tepq_pkg::t_ctrl_cmd                   i_ctrl_cmd,
    output tepq_pkg::t_dp_status                  o_dp_status,
    input  wire                                   i_cfg_wr_en,
    input  wire  [tepq_pkg::TEPQ_WIN_W-1:0]       i_cfg_wr_data,
    input  wire  [1:0]                            i_command,
    input  wire  [tepq_pkg::TEPQ_TIME_W-1:0]      i_event_time,
    input  wire  [tepq_pkg::TEPQ_POS_W-1:0]       i_event_col,
    input  wire  [tepq_pkg::TEPQ_POS_W-1:0]       i_event_row,
    input  wire  [tepq_pkg::TEPQ_TIME_W-1:0]      i_now_ms,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic                                  o_head_ready,
    output logic                                  o_popped_valid,
    output logic [tepq_pkg::TEPQ_TIME_W-1:0]      o_popped_time,
    output logic [tepq_pkg::TEPQ_POS_W-1:0]       o_popped_col,
    output logic [tepq_pkg::TEPQ_POS_W-1:0]       o_popped_row,
    output logic [1:0]                            o_status,
    output logic [tepq_pkg::TEPQ_OCC_W-1:0]       o_occupancy
);
    import tepq_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_entry                  r_ent [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]  w_gt;
    logic [CW-1:0]           r_count;
    logic [TEPQ_WIN_W-1:0]   r_window;
    logic [TEPQ_TIME_W-1:0]  r_now;
    logic                    r_pv;
    t_entry                  r_pop;
    t_status                 r_st;
    t_status                 n_st;
    t_cmd                    w_cmd;
    t_entry                  w_new;
    logic                    w_full;
    logic                    w_empty;
    logic                    w_do_ins;
    logic                    w_do_pop;
    logic [TEPQ_TIME_W-1:0]  w_head;
    logic [TEPQ_TIME_W-1:0]  w_diff;
    logic                    w_ready;
    logic [TEPQ_OCC_W-1:0]   w_occ;

    assign w_cmd   = t_cmd'(i_command);
    assign w_new   = '{ev_time: i_event_time, ev_col: i_event_col, ev_row: i_event_row};
    assign w_full  = (r_count == CW'(QUEUE_DEPTH));
    assign w_empty = (r_count == '0);

    always_comb begin
        w_do_ins = 1'b0;
        w_do_pop = 1'b0;
        n_st     = ST_OK;
        case (w_cmd)
            CMD_INSERT: begin
                w_do_ins = i_ctrl_cmd.accept && !w_full;
                n_st     = w_full ? ST_FULL : ST_OK;
            end
            CMD_POP: begin
                w_do_pop = i_ctrl_cmd.accept && !w_empty;
                n_st     = w_empty ? ST_EMPTY : ST_OK;
            end
            default: begin
                n_st = ST_OK;
            end
        endcase
    end

    // Each cell compares itself with the new time; the flags rise monotonically
    // along the sorted row, so a cell whose left neighbor is later shifts right.
    for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
        t_entry w_prev;
        t_entry w_next;
        logic   w_prev_gt;

        assign w_gt[gi] = (CW'(gi) < r_count) && (r_ent[gi].ev_time > i_event_time);

        if (gi == 0) begin : g_first
            assign w_prev    = w_new;
            assign w_prev_gt = 1'b0;
        end else begin : g_rest
            assign w_prev    = r_ent[gi-1];
            assign w_prev_gt = w_gt[gi-1];
        end

        if (gi == QUEUE_DEPTH - 1) begin : g_last
            assign w_next = r_ent[gi];
        end else begin : g_inner
            assign w_next = r_ent[gi+1];
        end

        always_ff @(posedge i_clk) begin
            if (w_do_ins) begin
                if (w_prev_gt) begin
                    r_ent[gi] <= w_prev;
                end else if (w_gt[gi] || (CW'(gi) == r_count)) begin
                    r_ent[gi] <= w_new;
                end
            end else if (w_do_pop) begin
                r_ent[gi] <= w_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_window <= TEPQ_WINDOW_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_window <= i_cfg_wr_data;
            end
            if (w_do_ins) begin
                r_count <= r_count + CW'(1);
            end else if (w_do_pop) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl_cmd.accept) begin
            r_now <= i_now_ms;
            r_st  <= n_st;
            r_pv  <= w_do_pop;
            r_pop <= w_do_pop ? r_ent[0] : '0;
        end
    end

    assign w_head  = r_ent[0].ev_time;
    assign w_diff  = (w_head >= r_now) ? (w_head - r_now) : (r_now - w_head);
    assign w_ready = !w_empty && (w_diff < {{(TEPQ_TIME_W-TEPQ_WIN_W){1'b0}}, r_window});

    if (CW >= TEPQ_OCC_W) begin : g_occ_trunc
        assign w_occ = r_count[TEPQ_OCC_W-1:0];
    end else begin : g_occ_ext
        assign w_occ = {{(TEPQ_OCC_W-CW){1'b0}}, r_count};
    end

    assign o_dp_status.out_free = !o_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (i_ctrl_cmd.load) begin
            o_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl_cmd.load) begin
            o_head_ready   <= w_ready;
            o_popped_valid <= r_pv;
            o_popped_time  <= r_pop.ev_time;
            o_popped_col   <= r_pop.ev_col;
            o_popped_row   <= r_pop.ev_row;
            o_status       <= r_st;
            o_occupancy    <= w_occ;
        end
    end

    `TEPQ_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(QUEUE_DEPTH), "entry count above depth")
    `TEPQ_ASSERT_NEXT(a_full_drop, i_clk, i_rst_n, i_ctrl_cmd.accept && w_cmd == CMD_INSERT && w_full, $stable(r_count), "insert into full queue changed the count")
    `TEPQ_ASSERT_NEXT(a_pop_dec, i_clk, i_rst_n, w_do_pop, r_count == $past(r_count) - CW'(1), "pop did not remove one entry")
    `TEPQ_ASSERT_NOW(a_load_free, i_clk, i_rst_n, i_ctrl_cmd.load, !o_out_valid || i_out_ready, "result loaded over a waiting beat")

endmodule

`default_nettype wire

// ===== rtl/timed_event_priority_queue_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel     Direction  Beat contents
// s_axis      in         tuser: command; tdata: event_time, event_col, event_row, now_ms
// m_axis      out        tuser: popped_valid; tdata: head_ready, popped_time,
//                        popped_col, popped_row, status, occupancy
// cfg         in         i_cfg_wr_data: ready_window, written when i_cfg_wr_en is high
//
// The sorted cell row is updated in the accept cycle, and the head readiness check on
// the new head is made in the evaluate state that follows, once m_axis is free for it.
// A new beat is accepted while a finished result still waits on m_axis.
// Reset is synchronous and active low; it empties the queue and sets the window to 6.
// The store itself needs no clearing pass after reset.

module timed_event_priority_queue_core #(
    parameter int QUEUE_DEPTH = tepq_pkg::TEPQ_DEPTH
) (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [31:0] event_time, [39:32] event_col, [47:40] event_row, [79:48] now_ms
    input  wire  [tepq_pkg::TEPQ_IN_DATA_W-1:0]     s_axis_tdata,
    // [1:0] command
    input  wire  [1:0]                              s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire                                     m_axis_tready,
    // [0] head_ready, [32:1] popped_time, [40:33] popped_col, [48:41] popped_row,
    // [50:49] status, [57:51] occupancy, [63:58] zero
    output logic [tepq_pkg::TEPQ_OUT_DATA_W-1:0]    m_axis_tdata,
    // [0] popped_valid
    output logic                                    m_axis_tuser,
    input  wire                                     i_cfg_wr_en,
    input  wire  [tepq_pkg::TEPQ_WIN_W-1:0]         i_cfg_wr_data
);
    import tepq_pkg::*;

    t_ctrl_cmd               w_cmd;
    t_dp_status              w_status;
    logic                    w_head_ready;
    logic [TEPQ_TIME_W-1:0]  w_pt;
    logic [TEPQ_POS_W-1:0]   w_pc;
    logic [TEPQ_POS_W-1:0]   w_pr;
    logic [1:0]              w_st;
    logic [TEPQ_OCC_W-1:0]   w_occ;

    tepq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_dp_status (w_status),
        .o_ctrl_cmd  (w_cmd)
    );

    tepq_datapath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl_cmd     (w_cmd),
        .o_dp_status    (w_status),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_command      (s_axis_tuser),
        .i_event_time   (s_axis_tdata[31:0]),
        .i_event_col    (s_axis_tdata[39:32]),
        .i_event_row    (s_axis_tdata[47:40]),
        .i_now_ms       (s_axis_tdata[79:48]),
        .o_out_valid    (m_axis_tvalid),
        .i_out_ready    (m_axis_tready),
        .o_head_ready   (w_head_ready),
        .o_popped_valid (m_axis_tuser),
        .o_popped_time  (w_pt),
        .o_popped_col   (w_pc),
        .o_popped_row   (w_pr),
        .o_status       (w_st),
        .o_occupancy    (w_occ)
    );

    assign m_axis_tdata = {6'b0, w_occ, w_st, w_pr, w_pc, w_pt, w_head_ready};

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import tepq_pkg::*;

    localparam logic [1:0] CMD_RESERVED = 2'd3;
    localparam int IDLE_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PRESSURE_CYCLES = 400;
    localparam int PHASE_COUNT = 8;
    localparam int PHASE_ITEMS = 240;
    localparam int SEGMENT_ITEMS = 60;
    localparam int REPORT_LINES = 100;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] ev_time;
        logic [7:0]  ev_col;
        logic [7:0]  ev_row;
        logic [31:0] now_ms;
    } t_command_beat;

    typedef struct packed {
        logic        head_ready;
        logic        popped_valid;
        logic [31:0] popped_time;
        logic [7:0]  popped_col;
        logic [7:0]  popped_row;
        t_status     status;
        logic [6:0]  occupancy;
    } t_outcome;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       s_axis_tvalid = 1'b0;
    logic                       s_axis_tready;
    // now_ms, event_row, event_col, event_time from the top down; event_time in the low bits.
    logic [TEPQ_IN_DATA_W-1:0]  s_axis_tdata = '0;
    // command
    logic [1:0]                 s_axis_tuser = '0;
    logic                       m_axis_tvalid;
    logic                       m_axis_tready = 1'b0;
    // head_ready, popped_time, popped_col, popped_row, status, occupancy from bit 0 up.
    logic [TEPQ_OUT_DATA_W-1:0] m_axis_tdata;
    // popped_valid
    logic                       m_axis_tuser;
    logic                       i_cfg_wr_en = 1'b0;
    logic [TEPQ_WIN_W-1:0]      i_cfg_wr_data = '0;

    t_command_beat cmd_backlog[$];
    t_outcome      outcome_due[$];

    logic [31:0] sched_time [TEPQ_DEPTH];
    logic [7:0]  sched_col [TEPQ_DEPTH];
    logic [7:0]  sched_row [TEPQ_DEPTH];
    int          sched_count = 0;
    logic [7:0]  window_ms = TEPQ_WINDOW_RESET;

    bit in_beat = 1'b0;
    bit out_beat = 1'b0;
    int tx_wait = 0;
    int tx_burst = 0;
    int rx_wait = 0;
    int rx_burst = 0;
    int rx_hold_req = 0;
    int rx_hold_left = 0;
    int stall_cycles = 0;
    int results_seen = 0;
    int mismatch_count = 0;

    timed_event_priority_queue_core #(
        .QUEUE_DEPTH(TEPQ_DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_outcome run_command(t_command_beat c);
        t_outcome    o;
        int          pos;
        logic [31:0] head_gap;
        o = '0;
        o.status = ST_OK;
        if (c.cmd == CMD_INSERT) begin
            if (sched_count >= TEPQ_DEPTH) begin
                o.status = ST_FULL;
            end else begin
                pos = 0;
                while (pos < sched_count && sched_time[pos] <= c.ev_time) pos++;
                for (int i = sched_count; i > pos; i--) begin
                    sched_time[i] = sched_time[i-1];
                    sched_col[i] = sched_col[i-1];
                    sched_row[i] = sched_row[i-1];
                end
                sched_time[pos] = c.ev_time;
                sched_col[pos] = c.ev_col;
                sched_row[pos] = c.ev_row;
                sched_count++;
            end
        end else if (c.cmd == CMD_POP) begin
            if (sched_count == 0) begin
                o.status = ST_EMPTY;
            end else begin
                o.popped_valid = 1'b1;
                o.popped_time = sched_time[0];
                o.popped_col = sched_col[0];
                o.popped_row = sched_row[0];
                for (int i = 0; i + 1 < sched_count; i++) begin
                    sched_time[i] = sched_time[i+1];
                    sched_col[i] = sched_col[i+1];
                    sched_row[i] = sched_row[i+1];
                end
                sched_count--;
            end
        end
        if (sched_count > 0) begin
            head_gap = (sched_time[0] >= c.now_ms) ? sched_time[0] - c.now_ms
                                                   : c.now_ms - sched_time[0];
            o.head_ready = head_gap < {24'd0, window_ms};
        end
        o.occupancy = 7'(sched_count);
        return o;
    endfunction

    task automatic log_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= REPORT_LINES) $display("MISMATCH: %s", msg);
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            log_mismatch($sformatf("%s of result %0d: got %0h, expected %0h",
                                   name, results_seen, got, want));
        end
    endtask

    task automatic draw_wait(inout int burst, output int cycles);
        if (burst > 0) begin
            burst--;
            cycles = 0;
        end else if ($urandom_range(0, 19) == 0) begin
            burst = $urandom_range(8, 40);
            cycles = 0;
        end else begin
            cycles = $urandom_range(0, 11);
        end
    endtask

    task automatic add_beat(logic [1:0] cmd, logic [31:0] t, logic [7:0] col,
                            logic [7:0] row, logic [31:0] now);
        t_command_beat b;
        b.cmd = cmd;
        b.ev_time = t;
        b.ev_col = col;
        b.ev_row = row;
        b.now_ms = now;
        cmd_backlog.push_back(b);
    endtask

    // The first half of a phase mostly inserts so the queue runs full, the second
    // half mostly pops so it runs dry. Times cluster around a base so that ties
    // and ready heads are common.
    task automatic queue_phase(int n_items);
        logic [31:0] base;
        logic [31:0] t;
        logic [31:0] now;
        logic [1:0]  cmd;
        int          fill_pct;
        int          roll;
        base = 0;
        for (int k = 0; k < n_items; k++) begin
            if (k % SEGMENT_ITEMS == 0) begin
                case ($urandom_range(0, 3))
                    0: base = $urandom_range(0, 20);
                    1: base = 32'hFFFF_FFC0 + $urandom_range(0, 10);
                    default: base = $urandom;
                endcase
            end
            fill_pct = (k < n_items / 2) ? 85 : 10;
            roll = $urandom_range(0, 99);
            if (roll < 5) begin
                cmd = ($urandom_range(0, 1) != 0) ? CMD_QUERY : CMD_RESERVED;
            end else if (roll < 5 + fill_pct) begin
                cmd = CMD_INSERT;
            end else begin
                cmd = CMD_POP;
            end
            case ($urandom_range(0, 19))
                0: t = $urandom;
                1: t = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0;
                default: t = base + $urandom_range(0, 40);
            endcase
            now = ($urandom_range(0, 9) == 0) ? $urandom : base + $urandom_range(0, 60) - 10;
            add_beat(cmd, t, 8'($urandom), 8'($urandom), now);
        end
    endtask

    task automatic wait_idle();
        while (cmd_backlog.size() > 0 || s_axis_tvalid || outcome_due.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_window(logic [7:0] w);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= w;
        window_ms = w;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    always @(negedge i_clk) begin : source_proc
        logic          vld;
        t_command_beat item;
        vld = s_axis_tvalid;
        if (!i_rst_n) begin
            vld = 1'b0;
        end else begin
            if (in_beat) begin
                vld = 1'b0;
                draw_wait(tx_burst, tx_wait);
            end
            if (!vld) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                end else if (cmd_backlog.size() > 0) begin
                    item = cmd_backlog.pop_front();
                    s_axis_tdata <= {item.now_ms, item.ev_row, item.ev_col, item.ev_time};
                    s_axis_tuser <= item.cmd;
                    vld = 1'b1;
                end
            end
        end
        s_axis_tvalid <= vld;
    end

    always @(negedge i_clk) begin : sink_proc
        logic rdy;
        if (rx_hold_req > 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req = 0;
        end
        if (out_beat) draw_wait(rx_burst, rx_wait);
        if (!i_rst_n) begin
            rdy = 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            rdy = 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            rdy = 1'b0;
        end else begin
            rdy = 1'b1;
        end
        m_axis_tready <= rdy;
    end

    always @(posedge i_clk) begin : monitor_proc
        t_command_beat beat;
        t_outcome      got;
        t_outcome      want;
        in_beat = 1'b0;
        out_beat = 1'b0;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                in_beat = 1'b1;
                beat.cmd = s_axis_tuser;
                beat.ev_time = s_axis_tdata[31:0];
                beat.ev_col = s_axis_tdata[39:32];
                beat.ev_row = s_axis_tdata[47:40];
                beat.now_ms = s_axis_tdata[79:48];
                outcome_due.push_back(run_command(beat));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                out_beat = 1'b1;
                got.head_ready = m_axis_tdata[0];
                got.popped_valid = m_axis_tuser;
                got.popped_time = m_axis_tdata[32:1];
                got.popped_col = m_axis_tdata[40:33];
                got.popped_row = m_axis_tdata[48:41];
                got.status = t_status'(m_axis_tdata[50:49]);
                got.occupancy = m_axis_tdata[57:51];
                if (outcome_due.size() == 0) begin
                    log_mismatch($sformatf("result %0d arrived with none expected",
                                           results_seen));
                end else begin
                    want = outcome_due.pop_front();
                    compare_field("head_ready", got.head_ready, want.head_ready);
                    compare_field("popped_valid", got.popped_valid, want.popped_valid);
                    compare_field("popped_time", got.popped_time, want.popped_time);
                    compare_field("popped_col", got.popped_col, want.popped_col);
                    compare_field("popped_row", got.popped_row, want.popped_row);
                    compare_field("status", got.status, want.status);
                    compare_field("occupancy", got.occupancy, want.occupancy);
                end
                results_seen++;
            end
            if (in_beat || out_beat) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= IDLE_LIMIT) begin
                $display("testbench NOT OK");
                $finish;
            end
        end
    end

    initial begin : sequencer
        logic [7:0] w;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_beat(CMD_POP, 32'h0, 8'h00, 8'h00, 32'h0);
        add_beat(CMD_QUERY, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
        add_beat(CMD_RESERVED, 32'h0, 8'h00, 8'h00, 32'h0);
        add_beat(CMD_INSERT, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'hFFFF_FFFA);
        add_beat(CMD_INSERT, 32'h0, 8'h00, 8'h00, 32'hFFFF_FFFF);
        add_beat(CMD_INSERT, 32'h0, 8'h01, 8'h02, 32'd5);
        add_beat(CMD_INSERT, 32'd100, 8'h03, 8'h04, 32'd6);
        add_beat(CMD_POP, 32'h0, 8'h00, 8'h00, 32'h0);
        add_beat(CMD_POP, 32'h0, 8'h00, 8'h00, 32'd95);
        add_beat(CMD_QUERY, 32'h0, 8'h00, 8'h00, 32'd106);
        add_beat(CMD_QUERY, 32'h0, 8'h00, 8'h00, 32'd94);
        add_beat(CMD_POP, 32'h0, 8'h00, 8'h00, 32'h0);
        add_beat(CMD_POP, 32'h0, 8'h00, 8'h00, 32'h0);
        add_beat(CMD_POP, 32'h0, 8'h00, 8'h00, 32'h0);
        add_beat(CMD_INSERT, 32'hAAAA_AAAA, 8'h55, 8'hAA, 32'h5555_5555);
        add_beat(CMD_INSERT, 32'h5555_5555, 8'hAA, 8'h55, 32'hAAAA_AAAA);
        add_beat(CMD_INSERT, 32'h5555_5555, 8'h0F, 8'hF0, 32'h5555_5556);
        add_beat(CMD_RESERVED, 32'hFFFF_FFFF, 8'hFF, 8'hFF, 32'h5555_5550);
        add_beat(CMD_POP, 32'h0, 8'h00, 8'h00, 32'h5555_5555);
        add_beat(CMD_POP, 32'h0, 8'h00, 8'h00, 32'hAAAA_AAAA);
        add_beat(CMD_POP, 32'h0, 8'h00, 8'h00, 32'h0);

        for (int p = 0; p < PHASE_COUNT; p++) begin
            if (p > 0) begin
                wait_idle();
                case (p)
                    1, 5: w = 8'd1;
                    2, 6: w = 8'd255;
                    4: w = TEPQ_WINDOW_RESET;
                    default: w = 8'($urandom_range(2, 254));
                endcase
                set_window(w);
            end
            if (p == 2) begin
                @(posedge i_clk);
                rx_hold_req = PRESSURE_CYCLES;
            end
            queue_phase(PHASE_ITEMS);
        end
        wait_idle();

        if (mismatch_count == 0) $display("testbench OK");
        else $display("testbench NOT OK");
        $finish;
    end

endmodule
